@@ design/heightmap_vertex_attributes_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the heightmap vertex attribute pipeline
// Checks run in simulation only; synthesis sees empty macros.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_ATTRIBUTES_ASSERT_SVH
`define HEIGHTMAP_VERTEX_ATTRIBUTES_ASSERT_SVH

`ifndef SYNTHESIS
// Plain property, checked on every edge outside reset
`define HVA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define HVA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define HVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HVA_ASSERT(lbl, prop, msg)
`define HVA_ASSERT_IMP(lbl, ante, cons, msg)
`define HVA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/hva_pkg.sv @@
// ----------------------------------------------------------------------------
// hva_pkg
// Shared types, constants and the biome color table of the vertex pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hva_pkg;

    // World position scale per chunk
    localparam int CHUNK_SIZE = 16;

    // Datapath widths
    localparam int HGT_W     = 24;
    localparam int DIFF_W    = 25;
    localparam int MAG_W     = 24;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int RAD_W     = 50;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int NRM_NUM_W = 40;
    localparam int NRM_Q_W   = 16;
    localparam int TEX_NUM_W = 25;
    localparam int TEX_DEN_W = 10;
    localparam int TEX_Q_W   = 16;
    localparam int YU_W      = 28;
    localparam int YP_W      = 60;

    // Height scale 0.8: floor((8h + 5) / 10) through a biased reciprocal multiply
    localparam logic signed [28:0] Y_BIAS   = 29'sd167772160;
    localparam logic [31:0]        Y_MAGIC  = 32'hCCCC_CCCD;
    localparam int                 Y_SHIFT  = 35;
    localparam logic [24:0]        Y_OFFSET = 25'd16777216;

    // Normal constants: up component 2.0 in Q.8 and its square
    localparam logic [MAG_W-1:0]   UP_MAG   = 24'd512;
    localparam logic [RAD_W-1:0]   UP_SQ    = 50'd262144;
    localparam logic [NRM_Q_W-1:0] NRM_MAX  = 16'd32767;
    localparam logic [16:0]        TEX_ONE  = 17'd65536;

    // Detail level codes
    localparam logic [1:0] LOD_SCALE_08 = 2'd2;
    localparam logic [1:0] LOD_SCALE_05 = 2'd3;

    typedef enum logic [2:0] {
        REG_LOD_LEVEL  = 3'd0,
        REG_CHUNK_X    = 3'd1,
        REG_CHUNK_Z    = 3'd2,
        REG_MAP_WIDTH  = 3'd3,
        REG_MAP_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TEX_ZERO = 2'd0,
        TEX_FULL = 2'd1,
        TEX_DIV  = 2'd2
    } tex_mode_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Per-item data that rides alongside the arithmetic
    typedef struct packed {
        logic                  detailed;
        logic [1:0]            lod;
        logic                  neg_x;
        logic                  neg_z;
        logic [MAG_W-1:0]      mag_x;
        logic [MAG_W-1:0]      mag_z;
        logic signed [25:0]    world_x;
        logic signed [25:0]    world_z;
        logic signed [23:0]    world_y;
        logic signed [23:0]    hc;
        rgb_t                  rgb;
        tex_mode_t             u_mode;
        tex_mode_t             v_mode;
        logic [TEX_NUM_W-1:0]  u_num;
        logic [TEX_NUM_W-1:0]  v_num;
        logic [TEX_DEN_W-1:0]  u_den;
        logic [TEX_DEN_W-1:0]  v_den;
    } hva_side_t;

    // Biome color lookup; unknown ids fall back to gray
    function automatic rgb_t biome_color(input logic [7:0] id);
        rgb_t c;
        unique case (id)
            8'd0:    c = '{red: 8'd51,  green: 8'd153, blue: 8'd51};
            8'd1:    c = '{red: 8'd204, green: 8'd204, blue: 8'd102};
            8'd2:    c = '{red: 8'd102, green: 8'd102, blue: 8'd204};
            8'd3:    c = '{red: 8'd153, green: 8'd102, blue: 8'd51};
            8'd4:    c = '{red: 8'd230, green: 8'd230, blue: 8'd230};
            default: c = '{red: 8'd128, green: 8'd128, blue: 8'd128};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/hva_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// hva_sqrt_pipe
// Integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hva_sqrt_pipe #(
    parameter int IN_W = 50
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [IN_W-1:0]      radicand,
    output logic      [IN_W/2-1:0]    root
);

    localparam int RW = IN_W / 2;

    logic [IN_W-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [IN_W-1:0] rem_next  [RW];
    logic [RW-1:0]   root_next [RW];

    // Try to set one root bit per stage
    always_comb
    begin
        logic [IN_W-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [IN_W-1:0] trial;
        for (int k = 0; k < RW; k++)
        begin
            rem_in  = (k == 0) ? radicand : rem_reg[(k == 0) ? 0 : k - 1];
            root_in = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k - 1];
            trial   = (IN_W'(root_in) << (RW - k)) | (IN_W'(1) << (2 * (RW - 1 - k)));
            if (rem_in >= trial)
            begin
                rem_next[k]  = rem_in - trial;
                root_next[k] = root_in | (RW'(1) << (RW - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_in;
                root_next[k] = root_in;
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

`default_nettype wire

@@ design/hva_div_pipe.sv @@
// ----------------------------------------------------------------------------
// hva_div_pipe
// Unsigned restoring divider, one quotient bit per register stage.
// The caller guarantees the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hva_div_pipe #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 25,
    parameter int QUO_W = 16
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;

    logic [NUM_W-1:0] rem_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [NUM_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];

    // Compare and subtract the shifted divisor in each stage
    always_comb
    begin
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] diff;
        for (int k = 0; k < QUO_W; k++)
        begin
            rem_in  = (k == 0) ? num : rem_reg[(k == 0) ? 0 : k - 1];
            den_in  = (k == 0) ? den : den_reg[(k == 0) ? 0 : k - 1];
            quo_in  = (k == 0) ? '0  : quo_reg[(k == 0) ? 0 : k - 1];
            shifted = CMP_W'(den_in) << (QUO_W - 1 - k);
            diff    = CMP_W'(rem_in) - shifted;
            if (CMP_W'(rem_in) >= shifted)
            begin
                rem_next[k] = diff[NUM_W-1:0];
                quo_next[k] = quo_in | (QUO_W'(1) << (QUO_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_in;
                quo_next[k] = quo_in;
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= (k == 0) ? den : den_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

@@ design/heightmap_vertex_attributes.sv @@
// ----------------------------------------------------------------------------
// heightmap_vertex_attributes
// Turns one heightmap sample into one terrain vertex: world position,
// scaled height, central-difference normal, texture coordinate and color.
//
//   channel | direction | handshake             | payload
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready   | grid, heights, biome_id
//   out     | out       | out_valid / out_ready | world, normal, tex, color
//
// One transaction enters per cycle unless the output stalls; a vertex passes
// stages 0 to 2, the 25-stage square root, stage 3, the 16-stage normal and texture
// dividers, then the output register. Reset clears valid bits and loads the
// register defaults. When the output register holds an untaken transaction,
// every stage holds. Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "heightmap_vertex_attributes_assert.svh"

module heightmap_vertex_attributes
    import hva_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [20:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         grid_x,
    input  wire logic [7:0]         grid_z,
    input  wire logic signed [23:0] h_center,
    input  wire logic signed [23:0] h_left,
    input  wire logic signed [23:0] h_right,
    input  wire logic signed [23:0] h_near,
    input  wire logic signed [23:0] h_far,
    input  wire logic [7:0]         biome_id,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [25:0]      world_x,
    output logic signed [23:0]      world_y,
    output logic signed [25:0]      world_z,
    output logic signed [15:0]      normal_x,
    output logic signed [15:0]      normal_y,
    output logic signed [15:0]      normal_z,
    output logic [16:0]             tex_u,
    output logic [16:0]             tex_v,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue
);

    localparam logic signed [25:0] CHUNK_MUL = 26'(CHUNK_SIZE);

    // Configuration registers
    logic [1:0]  lod_level_reg;
    logic [20:0] chunk_x_reg;
    logic [20:0] chunk_z_reg;
    logic [8:0]  map_width_reg;
    logic [8:0]  map_height_reg;

    // Pipeline control
    logic adv;
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic [ROOT_W-1:0]  vq_reg;
    logic [NRM_Q_W-1:0] vd_reg;
    logic out_valid_reg;

    // Stage payloads
    hva_side_t              sb0_reg, sb1_reg, sb2_reg, sb3_reg;
    hva_side_t              sbq_reg [ROOT_W];
    hva_side_t              sbd_reg [NRM_Q_W];
    logic signed [DIFF_W-1:0] dx0_reg, dz0_reg;
    logic [YU_W-1:0]        u0_reg;
    logic [SQ_W-1:0]        sqx1_reg, sqz1_reg;
    logic [YP_W-1:0]        prod1_reg;
    logic [RAD_W-1:0]       n2_reg;
    logic [NRM_NUM_W-1:0]   numx3_reg, numy3_reg, numz3_reg;
    logic [ROOT_W-1:0]      den3_reg;

    // Stage 0 logic
    hva_side_t              sb0_next;
    logic signed [DIFF_W-1:0] dx0_next, dz0_next;
    logic [YU_W-1:0]        u0_next;
    // Stage 1 and 2 logic
    hva_side_t              sb1_next, sb2_next;
    logic [MAG_W-1:0]       magx1, magz1;
    logic [RAD_W-1:0]       n2_next;
    // Stage 3 and output logic
    logic [ROOT_W-1:0]      root;
    logic [NRM_Q_W-1:0]     qx, qy, qz;
    logic [TEX_Q_W-1:0]     qu, qv;
    hva_side_t              sbl;

    // Output registers
    logic signed [25:0] world_x_reg, world_z_reg;
    logic signed [23:0] world_y_reg;
    logic signed [15:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic [16:0]        tex_u_reg, tex_v_reg;
    rgb_t               rgb_reg;
    logic signed [15:0] nx_next, ny_next, nz_next;
    logic [16:0]        tu_next, tv_next;

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lod_level_reg  <= 2'd0;
            chunk_x_reg    <= 21'd0;
            chunk_z_reg    <= 21'd0;
            map_width_reg  <= 9'd16;
            map_height_reg <= 9'd16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOD_LEVEL:  lod_level_reg  <= cfg_data[1:0];
                REG_CHUNK_X:    chunk_x_reg    <= cfg_data;
                REG_CHUNK_Z:    chunk_z_reg    <= cfg_data;
                REG_MAP_WIDTH:  map_width_reg  <= cfg_data[8:0];
                REG_MAP_HEIGHT: map_height_reg <= cfg_data[8:0];
                default:        ;
            endcase
        end
    end

    // Stage 0: edge substitution, differences, position, texture setup
    always_comb
    begin
        logic signed [23:0] hl, hr, hn, hf;
        logic signed [28:0] u_wide;
        logic signed [9:0]  du, dv;
        sb0_next = '0;
        hl = (grid_x != 8'd0) ? h_left : h_center;
        hr = ((10'(grid_x) + 10'd1) < 10'(map_width_reg)) ? h_right : h_center;
        hn = (grid_z != 8'd0) ? h_near : h_center;
        hf = ((10'(grid_z) + 10'd1) < 10'(map_height_reg)) ? h_far : h_center;
        dx0_next = DIFF_W'(hl) - DIFF_W'(hr);
        dz0_next = DIFF_W'(hn) - DIFF_W'(hf);
        u_wide   = (29'(h_center) <<< 3) + 29'sd5 + Y_BIAS;
        u0_next  = u_wide[YU_W-1:0];

        sb0_next.detailed = lod_level_reg[1];
        sb0_next.lod      = lod_level_reg;
        sb0_next.hc       = h_center;
        sb0_next.world_x  = 26'($signed(26'(signed'(chunk_x_reg))) * CHUNK_MUL)
                            + $signed(26'(grid_x));
        sb0_next.world_z  = 26'($signed(26'(signed'(chunk_z_reg))) * CHUNK_MUL)
                            + $signed(26'(grid_z));
        sb0_next.rgb      = biome_color(biome_id);

        // Texture divisor is the map size, one less at the voxel levels
        du = lod_level_reg[1] ? $signed(10'(map_width_reg))
                              : $signed(10'(map_width_reg)) - 10'sd1;
        dv = lod_level_reg[1] ? $signed(10'(map_height_reg))
                              : $signed(10'(map_height_reg)) - 10'sd1;
        priority if (du <= 10'sd0)                   sb0_next.u_mode = TEX_ZERO;
        else if ($signed(10'(grid_x)) >= du)         sb0_next.u_mode = TEX_FULL;
        else                                         sb0_next.u_mode = TEX_DIV;
        priority if (dv <= 10'sd0)                   sb0_next.v_mode = TEX_ZERO;
        else if ($signed(10'(grid_z)) >= dv)         sb0_next.v_mode = TEX_FULL;
        else                                         sb0_next.v_mode = TEX_DIV;
        sb0_next.u_num = {grid_x, 17'd0} + TEX_NUM_W'(du[8:0]);
        sb0_next.v_num = {grid_z, 17'd0} + TEX_NUM_W'(dv[8:0]);
        sb0_next.u_den = {du[8:0], 1'b0};
        sb0_next.v_den = {dv[8:0], 1'b0};
    end

    // Stage 1: magnitudes
    always_comb
    begin
        logic [DIFF_W-1:0] ax, az;
        ax = dx0_reg[DIFF_W-1] ? DIFF_W'(-dx0_reg) : DIFF_W'(dx0_reg);
        az = dz0_reg[DIFF_W-1] ? DIFF_W'(-dz0_reg) : DIFF_W'(dz0_reg);
        magx1 = ax[MAG_W-1:0];
        magz1 = az[MAG_W-1:0];
        sb1_next       = sb0_reg;
        sb1_next.neg_x = dx0_reg[DIFF_W-1];
        sb1_next.neg_z = dz0_reg[DIFF_W-1];
        sb1_next.mag_x = magx1;
        sb1_next.mag_z = magz1;
    end

    // Stage 2: radicand and scaled height
    always_comb
    begin
        logic [24:0]        q10;
        logic signed [24:0] half;
        n2_next  = RAD_W'(sqx1_reg) + RAD_W'(sqz1_reg) + UP_SQ;
        q10      = prod1_reg[YP_W-1:Y_SHIFT] - Y_OFFSET;
        half     = (25'(sb1_reg.hc) + 25'sd1) >>> 1;
        sb2_next = sb1_reg;
        priority if (sb1_reg.lod == LOD_SCALE_08) sb2_next.world_y = q10[23:0];
        else if (sb1_reg.lod == LOD_SCALE_05)     sb2_next.world_y = half[23:0];
        else                                      sb2_next.world_y = sb1_reg.hc;
    end

    // Advance front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb0_reg   <= sb0_next;
            dx0_reg   <= dx0_next;
            dz0_reg   <= dz0_next;
            u0_reg    <= u0_next;
            sb1_reg   <= sb1_next;
            sqx1_reg  <= magx1 * magx1;
            sqz1_reg  <= magz1 * magz1;
            prod1_reg <= u0_reg * Y_MAGIC;
            sb2_reg   <= sb2_next;
            n2_reg    <= n2_next;
        end
    end

    hva_sqrt_pipe #(
        .IN_W (RAD_W)
    ) u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (n2_reg),
        .root     (root)
    );

    // Carry side data past the square root, then form the dividends
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sbq_reg[0] <= sb2_reg;
            for (int k = 1; k < ROOT_W; k++)
            begin
                sbq_reg[k] <= sbq_reg[k-1];
            end
            sb3_reg   <= sbq_reg[ROOT_W-1];
            numx3_reg <= (NRM_NUM_W'(sbq_reg[ROOT_W-1].mag_x) << 15) + NRM_NUM_W'(root >> 1);
            numy3_reg <= (NRM_NUM_W'(UP_MAG) << 15) + NRM_NUM_W'(root >> 1);
            numz3_reg <= (NRM_NUM_W'(sbq_reg[ROOT_W-1].mag_z) << 15) + NRM_NUM_W'(root >> 1);
            den3_reg  <= root;
            sbd_reg[0] <= sb3_reg;
            for (int k = 1; k < NRM_Q_W; k++)
            begin
                sbd_reg[k] <= sbd_reg[k-1];
            end
        end
    end

    hva_div_pipe #(.NUM_W(NRM_NUM_W), .DEN_W(ROOT_W), .QUO_W(NRM_Q_W)) u_div_x (
        .clk (clk), .en (adv), .num (numx3_reg), .den (den3_reg), .quo (qx)
    );
    hva_div_pipe #(.NUM_W(NRM_NUM_W), .DEN_W(ROOT_W), .QUO_W(NRM_Q_W)) u_div_y (
        .clk (clk), .en (adv), .num (numy3_reg), .den (den3_reg), .quo (qy)
    );
    hva_div_pipe #(.NUM_W(NRM_NUM_W), .DEN_W(ROOT_W), .QUO_W(NRM_Q_W)) u_div_z (
        .clk (clk), .en (adv), .num (numz3_reg), .den (den3_reg), .quo (qz)
    );
    hva_div_pipe #(.NUM_W(TEX_NUM_W), .DEN_W(TEX_DEN_W), .QUO_W(TEX_Q_W)) u_div_u (
        .clk (clk), .en (adv), .num (sb3_reg.u_num), .den (sb3_reg.u_den), .quo (qu)
    );
    hva_div_pipe #(.NUM_W(TEX_NUM_W), .DEN_W(TEX_DEN_W), .QUO_W(TEX_Q_W)) u_div_v (
        .clk (clk), .en (adv), .num (sb3_reg.v_num), .den (sb3_reg.v_den), .quo (qv)
    );

    assign sbl = sbd_reg[NRM_Q_W-1];

    // Sign, saturate and select final fields
    always_comb
    begin
        if (sbl.detailed)
        begin
            nx_next = sbl.neg_x ? 16'(~qx + 16'd1) : ((qx > NRM_MAX) ? NRM_MAX : qx);
            ny_next = (qy > NRM_MAX) ? NRM_MAX : qy;
            nz_next = sbl.neg_z ? 16'(~qz + 16'd1) : ((qz > NRM_MAX) ? NRM_MAX : qz);
        end
        else
        begin
            nx_next = 16'sd0;
            ny_next = NRM_MAX;
            nz_next = 16'sd0;
        end
        unique case (sbl.u_mode)
            TEX_FULL: tu_next = TEX_ONE;
            TEX_DIV:  tu_next = 17'(qu);
            default:  tu_next = 17'd0;
        endcase
        unique case (sbl.v_mode)
            TEX_FULL: tv_next = TEX_ONE;
            TEX_DIV:  tv_next = 17'(qv);
            default:  tv_next = 17'd0;
        endcase
    end

    // Load output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            world_x_reg  <= sbl.world_x;
            world_y_reg  <= sbl.world_y;
            world_z_reg  <= sbl.world_z;
            normal_x_reg <= nx_next;
            normal_y_reg <= ny_next;
            normal_z_reg <= nz_next;
            tex_u_reg    <= tu_next;
            tex_v_reg    <= tv_next;
            rgb_reg      <= sbl.rgb;
        end
    end

    // Move valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            vq_reg        <= '0;
            v3_reg        <= 1'b0;
            vd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            vq_reg        <= {vq_reg[ROOT_W-2:0], v2_reg};
            v3_reg        <= vq_reg[ROOT_W-1];
            vd_reg        <= {vd_reg[NRM_Q_W-2:0], v3_reg};
            out_valid_reg <= vd_reg[NRM_Q_W-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign world_x   = world_x_reg;
    assign world_y   = world_y_reg;
    assign world_z   = world_z_reg;
    assign normal_x  = normal_x_reg;
    assign normal_y  = normal_y_reg;
    assign normal_z  = normal_z_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;
    assign red       = rgb_reg.red;
    assign green     = rgb_reg.green;
    assign blue      = rgb_reg.blue;

    // A live item always has a root of at least the up component
    `HVA_ASSERT_IMP(a_root_floor, vq_reg[ROOT_W-1], root >= ROOT_W'(UP_MAG), "root below up term")
    // The up quotient of a detailed item is never zero
    `HVA_ASSERT_IMP(a_up_nonzero, vd_reg[NRM_Q_W-1] && sbl.detailed, qy != 16'd0, "up quotient zero")
    // A stalled pipeline keeps its occupancy
    `HVA_ASSERT_NEXT(a_stall_hold, !adv, $stable(vd_reg), "valid bits moved during stall")
    // The u texture coordinate stays within one
    `HVA_ASSERT_IMP(a_tex_range, out_valid_reg, tex_u_reg <= TEX_ONE, "tex_u out of range")

endmodule

`default_nettype wire

@@ verif/hva_vertex_checker.sv @@
// ----------------------------------------------------------------------------
// hva_vertex_checker
// Watches the config, sample and vertex channels of the vertex pipeline,
// predicts each vertex from the accepted sample and the current register
// copy, and compares every vertex field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hva_vertex_checker
    import hva_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [20:0]        cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [7:0]         grid_x,
    input  wire logic [7:0]         grid_z,
    input  wire logic signed [23:0] h_center,
    input  wire logic signed [23:0] h_left,
    input  wire logic signed [23:0] h_right,
    input  wire logic signed [23:0] h_near,
    input  wire logic signed [23:0] h_far,
    input  wire logic [7:0]         biome_id,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [25:0] world_x,
    input  wire logic signed [23:0] world_y,
    input  wire logic signed [25:0] world_z,
    input  wire logic signed [15:0] normal_x,
    input  wire logic signed [15:0] normal_y,
    input  wire logic signed [15:0] normal_z,
    input  wire logic [16:0]        tex_u,
    input  wire logic [16:0]        tex_v,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    output int                      fail_count,
    output int                      vertices_pending
);

    typedef struct {
        logic signed [25:0] wx;
        logic signed [23:0] wy;
        logic signed [25:0] wz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
    } vertex_t;

    vertex_t vertex_q[$];

    // Shadow copy of the configuration registers
    logic [1:0]         lod;
    logic signed [20:0] chunk_x_r;
    logic signed [20:0] chunk_z_r;
    logic [8:0]         width_r;
    logic [8:0]         height_r;

    assign vertices_pending = vertex_q.size();

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= r + bit_v)
            begin
                n -= r + bit_v;
                r = (r >> 1) + bit_v;
            end
            else
                r >>= 1;
            bit_v >>= 2;
        end
        return r;
    endfunction

    // Scale one component to Q1.15 with rounding and saturation
    function automatic logic signed [15:0] unit_component(input longint c,
                                                          input longint unsigned s);
        longint unsigned m;
        longint unsigned k;
        m = (c < 0) ? -c : c;
        k = (m * 32768 + s / 2) / s;
        if (c < 0)
            return (k > 32768) ? -16'sd32768 : 16'(-longint'(k));
        return (k > 32767) ? 16'sd32767 : 16'(k);
    endfunction

    function automatic logic [16:0] tex_fraction(input longint g, input longint d);
        longint t;
        if (d <= 0)
            return 17'd0;
        t = (2 * g * 65536 + d) / (2 * d);
        return (t > 65536) ? TEX_ONE : 17'(t);
    endfunction

    function automatic vertex_t predict_vertex();
        vertex_t vx;
        longint  hc;
        longint  hl;
        longint  hr;
        longint  hn;
        longint  hf;
        longint  dx;
        longint  dz;
        longint  num;
        longint  w;
        longint  h;
        longint  gx;
        longint  gz;
        longint unsigned s;
        logic    detailed;
        rgb_t    c;
        hc = h_center;
        gx = grid_x;
        gz = grid_z;
        w = width_r;
        h = height_r;
        detailed = (lod >= LOD_SCALE_08);

        // Height scale, rounded with halves up
        if (lod == LOD_SCALE_08)
        begin
            num = 8 * hc + 5;
            vx.wy = 24'((num >= 0) ? num / 10 : -((-num + 9) / 10));
        end
        else if (lod == LOD_SCALE_05)
            vx.wy = 24'((hc + 1) >>> 1);
        else
            vx.wy = 24'(hc);

        vx.nx = 16'sd0;
        vx.ny = 16'sd32767;
        vx.nz = 16'sd0;
        if (detailed)
        begin
            // Replace neighbors past the map edge by the center height
            hl = (gx > 0) ? longint'(h_left) : hc;
            hr = (gx < w - 1) ? longint'(h_right) : hc;
            hn = (gz > 0) ? longint'(h_near) : hc;
            hf = (gz < h - 1) ? longint'(h_far) : hc;
            dx = hl - hr;
            dz = hn - hf;
            s = int_sqrt(longint'(dx * dx) + 262144 + longint'(dz * dz));
            vx.nx = unit_component(dx, s);
            vx.ny = unit_component(512, s);
            vx.nz = unit_component(dz, s);
        end

        vx.wx = 26'(longint'(chunk_x_r) * CHUNK_SIZE + gx);
        vx.wz = 26'(longint'(chunk_z_r) * CHUNK_SIZE + gz);
        vx.u = tex_fraction(gx, detailed ? w : w - 1);
        vx.v = tex_fraction(gz, detailed ? h : h - 1);

        case (biome_id)
            8'd0:    c = '{red: 8'd51,  green: 8'd153, blue: 8'd51};
            8'd1:    c = '{red: 8'd204, green: 8'd204, blue: 8'd102};
            8'd2:    c = '{red: 8'd102, green: 8'd102, blue: 8'd204};
            8'd3:    c = '{red: 8'd153, green: 8'd102, blue: 8'd51};
            8'd4:    c = '{red: 8'd230, green: 8'd230, blue: 8'd230};
            default: c = '{red: 8'd128, green: 8'd128, blue: 8'd128};
        endcase
        vx.r = c.red;
        vx.g = c.green;
        vx.b = c.blue;
        return vx;
    endfunction

    task automatic compare_field(input string nm, input longint e, input longint a);
        if (e != a)
        begin
            $error("%s: expected %0d, got %0d", nm, e, a);
            fail_count++;
        end
    endtask

    initial
        fail_count = 0;

    // Track register writes, predict on each sample, check each vertex
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t e;
        if (!rst_n)
        begin
            lod <= 2'd0;
            chunk_x_r <= '0;
            chunk_z_r <= '0;
            width_r <= 9'd16;
            height_r <= 9'd16;
        end
        else
        begin
            if (in_valid && in_ready)
                vertex_q.insert(vertex_q.size(), predict_vertex());
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOD_LEVEL:  lod <= cfg_data[1:0];
                    REG_CHUNK_X:    chunk_x_r <= cfg_data;
                    REG_CHUNK_Z:    chunk_z_r <= cfg_data;
                    REG_MAP_WIDTH:  width_r <= cfg_data[8:0];
                    REG_MAP_HEIGHT: height_r <= cfg_data[8:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (vertex_q.size() == 0)
                begin
                    $error("vertex with no sample waiting");
                    fail_count++;
                end
                else
                begin
                    e = vertex_q.pop_front();
                    compare_field("world_x", e.wx, world_x);
                    compare_field("world_y", e.wy, world_y);
                    compare_field("world_z", e.wz, world_z);
                    compare_field("normal_x", e.nx, normal_x);
                    compare_field("normal_y", e.ny, normal_y);
                    compare_field("normal_z", e.nz, normal_z);
                    compare_field("tex_u", e.u, tex_u);
                    compare_field("tex_v", e.v, tex_v);
                    compare_field("red", e.r, red);
                    compare_field("green", e.g, green);
                    compare_field("blue", e.b, blue);
                end
            end
        end
    end

endmodule

@@ verif/tb_heightmap_vertex_attributes.sv @@
// ----------------------------------------------------------------------------
// tb_heightmap_vertex_attributes
// Drives samples through the vertex pipeline over a series of register
// settings, with random idle bursts on both sides, and reports the verdict
// from the failure count of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heightmap_vertex_attributes;
    import hva_pkg::*;

    localparam int NUM_PHASES = 10;
    localparam int RANDOM_PER_PHASE = 43;
    localparam int DRAIN_CYCLES = 60;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [20:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         grid_x;
    logic [7:0]         grid_z;
    logic signed [23:0] h_center;
    logic signed [23:0] h_left;
    logic signed [23:0] h_right;
    logic signed [23:0] h_near;
    logic signed [23:0] h_far;
    logic [7:0]         biome_id;
    logic               out_valid;
    logic               out_ready;
    logic signed [25:0] world_x;
    logic signed [23:0] world_y;
    logic signed [25:0] world_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    int                 fail_count;
    int                 vertices_pending;
    logic               calm;
    int                 cur_width;
    int                 cur_height;

    heightmap_vertex_attributes u_top (.*);

    hva_vertex_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the vertex side in random bursts until the calm stretch
    initial
    begin
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [20:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for the pipeline to drain, then load a full register set
    task automatic apply_setting(input logic [1:0] lod, input logic [20:0] cx,
                                 input logic [20:0] cz, input int w, input int h);
        in_valid <= 1'b0;
        while (vertices_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_LOD_LEVEL, 21'(lod));
        write_reg(REG_CHUNK_X, cx);
        write_reg(REG_CHUNK_Z, cz);
        write_reg(REG_MAP_WIDTH, 21'(w));
        write_reg(REG_MAP_HEIGHT, 21'(h));
        cur_width = w;
        cur_height = h;
    endtask

    // Present one sample and hold it until the transaction completes
    task automatic send_sample(input logic [7:0] gx, input logic [7:0] gz,
                               input logic [23:0] hc, input logic [23:0] hl,
                               input logic [23:0] hr, input logic [23:0] hn,
                               input logic [23:0] hf, input logic [7:0] bio);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        grid_x <= gx;
        grid_z <= gz;
        h_center <= hc;
        h_left <= hl;
        h_right <= hr;
        h_near <= hn;
        h_far <= hf;
        biome_id <= bio;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [7:0] pick_grid(input int size);
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'(size - 1);
            2: return 8'd255;
            3: return 8'($urandom);
            default: return 8'($urandom_range(0, (size > 1) ? size - 1 : 0));
        endcase
    endfunction

    function automatic logic [23:0] pick_height(input logic [23:0] base);
        case ($urandom_range(0, 5))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'($urandom);
            default: return base + 24'(int'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    task automatic send_random();
        logic [23:0] hc;
        logic [7:0]  bio;
        hc = ($urandom_range(0, 1) == 0) ? 24'($urandom) :
             24'(int'($urandom_range(0, 65535)) - 32768);
        bio = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        send_sample(pick_grid(cur_width), pick_grid(cur_height), hc,
                    pick_height(hc), pick_height(hc), pick_height(hc),
                    pick_height(hc), bio);
    endtask

    task automatic send_directed();
        // Flat ground in the middle and at the corners
        send_sample(8'd7, 8'd7, 24'd1000, 24'd1000, 24'd1000, 24'd1000, 24'd1000, 8'd0);
        send_sample(8'd0, 8'd0, 24'd5, 24'd99, 24'd5, 24'd99, 24'd5, 8'd1);
        send_sample(8'd15, 8'd15, 24'd3, 24'd3, 24'h7F_FFFF, 24'd3, 24'h80_0000, 8'd2);
        // Sample outside the map: texture saturates, right and far neighbors replaced
        send_sample(8'd255, 8'd255, 24'h7F_FFFF, 24'd0, 24'd0, 24'd0, 24'd0, 8'd3);
        // Steepest slopes both ways
        send_sample(8'd5, 8'd6, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000,
                    24'h80_0000, 24'h7F_FFFF, 8'd4);
        send_sample(8'd6, 8'd5, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF,
                    24'h7F_FFFF, 24'h80_0000, 8'd5);
        // Rounding of odd and negative heights
        send_sample(8'd1, 8'd14, -24'sd3, 24'd0, 24'd1, -24'sd1, 24'd0, 8'd255);
        send_sample(8'd14, 8'd1, -24'sd5, 24'd2, 24'd0, 24'd0, 24'd2, 8'd6);
        send_sample(8'd8, 8'd8, 24'd7, 24'd300, -24'sd300, 24'd10, 24'd10, 8'd128);
        send_sample(8'd9, 8'd3, 24'd1, -24'sd1, 24'd1, 24'h55_5555, 24'h2A_AAAA, 8'd0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_LOD_LEVEL;
        cfg_data = '0;
        in_valid = 1'b0;
        grid_x = '0;
        grid_z = '0;
        h_center = '0;
        h_left = '0;
        h_right = '0;
        h_near = '0;
        h_far = '0;
        biome_id = '0;
        cur_width = 16;
        cur_height = 16;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults first, then a detailed level at the chunk extremes
        send_directed();
        apply_setting(LOD_SCALE_08, 21'h10_0000, 21'h0F_FFFF, 16, 16);
        send_directed();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: apply_setting(LOD_SCALE_05, 21'h0F_FFFF, 21'h10_0000, 1, 2);
                1: apply_setting(2'd1, 21'd5, -21'sd3, 0, 1);
                2: apply_setting(LOD_SCALE_08, 21'($urandom), 21'($urandom), 511, 0);
                3: apply_setting(LOD_SCALE_05, 21'h1F_FFFF, 21'd0, 256, 256);
                4: apply_setting(2'd0, 21'($urandom), 21'($urandom), 2, 256);
                default: apply_setting(2'($urandom), 21'($urandom), 21'($urandom),
                                       $urandom_range(1, 256), $urandom_range(1, 256));
            endcase
            if (p == NUM_PHASES - 1)
                calm = 1'b1;
            repeat (RANDOM_PER_PHASE) send_random();
        end
        in_valid <= 1'b0;

        while (vertices_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("heightmap_vertex_attributes: match");
        else
            $display("heightmap_vertex_attributes: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("heightmap_vertex_attributes: mismatch");
        $finish;
    end

endmodule

@@ heightmap_vertex_attributes.f @@
+incdir+design
design/hva_pkg.sv
design/hva_sqrt_pipe.sv
design/hva_div_pipe.sv
design/heightmap_vertex_attributes.sv
verif/hva_vertex_checker.sv
verif/tb_heightmap_vertex_attributes.sv
